// File: rtl/hfp_pkg.sv
// Package for the header field line parser: widths, codes, beat and result types.
// Holds the character constants and the keyword match helper used by the back end.
// No dependencies.
package hfp_pkg;

	localparam int MAX_LINE = 4096;
	// offsets and lengths are carried at the width of the result fields
	localparam int POS_W    = 13;
	localparam int NUM_W    = 64;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [NUM_W-1:0]  num_t;
	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QPTR_W:0]   qcount_t;

	localparam pos_t MAX_POS = POS_W'(MAX_LINE);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_S     = 8'h73;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_NAME,
		PH_SEP,
		PH_GAP,
		PH_VALUE,
		PH_ERR
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_NAME  = 3'd1,
		ST_NO_COLON = 3'd2,
		ST_NO_VALUE = 3'd3,
		ST_OVERFLOW = 3'd4,
		ST_TOO_LONG = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		KIND_BOOL   = 2'd0,
		KIND_UINT   = 2'd1,
		KIND_STRING = 2'd2
	} kind_t;

	// keyword tracker: 1..3 inside "true", 5..8 inside "false"
	typedef logic [3:0] wm_t;
	localparam wm_t WM_START   = 4'd0;
	localparam wm_t WM_T_FIRST = 4'd1;
	localparam wm_t WM_T_LAST  = 4'd3;
	localparam wm_t WM_TRUE    = 4'd4;
	localparam wm_t WM_F_FIRST = 4'd5;
	localparam wm_t WM_F_LAST  = 4'd8;
	localparam wm_t WM_FALSE   = 4'd9;
	localparam wm_t WM_FAIL    = 4'd15;

	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       line_end;
		logic       too_long;
		pos_t       pos;
		logic       is_blank;
		logic       is_lower;
		logic       is_digit;
		logic       is_colon;
		logic       is_quote;
	} item_t;

	typedef struct packed {
		status_t status;
		kind_t   kind;
		logic    flag;
		num_t    number;
		pos_t    name_start;
		pos_t    name_length;
		pos_t    value_start;
		pos_t    value_length;
	} res_t;

	function automatic logic [7:0] kw_char(input wm_t wm);
		logic [7:0] c;
		case (wm)
			4'd1:    c = CH_R;
			4'd2:    c = CH_U;
			4'd3:    c = CH_E;
			4'd5:    c = CH_A;
			4'd6:    c = CH_L;
			4'd7:    c = CH_S;
			4'd8:    c = CH_E;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic wm_t wm_next(input wm_t wm, input logic [7:0] c);
		wm_t nx;
		if (wm == WM_START) begin
			nx = (c == CH_T) ? WM_T_FIRST : (c == CH_F) ? WM_F_FIRST : WM_FAIL;
		end else if (wm inside {[WM_T_FIRST:WM_T_LAST], [WM_F_FIRST:WM_F_LAST]}) begin
			nx = (c == kw_char(wm)) ? wm + 4'd1 : WM_FAIL;
		end else begin
			nx = WM_FAIL;
		end
		return nx;
	endfunction

endpackage

// File: rtl/header_field_line_parser.sv
// Top level of the header field line parser: front end, beat queue and back end.
// Depends on hfp_pkg, hfp_front, hfp_queue and hfp_back.
//
// Use: feed one line as a stream of beats on the input channel (in_valid/in_ready),
// one character per beat with has_char set; a beat with has_char clear and line_end
// clear does nothing, one with has_char clear and line_end set closes an empty line.
// The beat with line_end set yields exactly one result beat on the output channel
// (out_valid/out_ready): status, value kind, boolean or integer value, and the
// offsets and lengths of name and value. When status is not ok, the other fields are 0.
// A line-end beat passes through the queue to the back end, which registers its result
// and raises out_valid; the pop waits while an earlier result is still held.
// Throughput: one beat per cycle apart from that wait, set by the single back-end update
// per queued beat (classification, multiply by ten with add, result selection).
// Reset clears the queue, the line state and the result valid flag; the next beat
// starts a new line.
// When the receiver stalls, the result holds in the output register; the back end keeps
// consuming beats up to the next line end, then the two-entry queue fills and
// in_ready drops.
module header_field_line_parser import hfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  character,
	input  logic        has_char,
	input  logic        line_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  value_kind,
	output logic        flag_value,
	output logic [63:0] number_value,
	output logic [12:0] name_start,
	output logic [12:0] name_length,
	output logic [12:0] value_start,
	output logic [12:0] value_length
);

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;
	res_t  res;

	hfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.character  (character),
		.has_char   (has_char),
		.line_end   (line_end),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	hfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	hfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item_ready (pop_ready),
		.item       (pop_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign status       = res.status;
	assign value_kind   = res.kind;
	assign flag_value   = res.flag;
	assign number_value = res.number;
	assign name_start   = res.name_start;
	assign name_length  = res.name_length;
	assign value_start  = res.value_start;
	assign value_length = res.value_length;

endmodule

// File: rtl/hfp_front.sv
// Front end of the header field line parser: takes input beats, classifies the character
// and stamps it with its line offset and the too-long mark. Depends on hfp_pkg.
module hfp_front import hfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       has_char,
	input  logic       line_end,
	output logic       push_valid,
	input  logic       push_ready,
	output item_t      push_item
);

	pos_t pos_q;
	logic accept;
	logic at_max;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid & push_ready;
	assign at_max     = (pos_q == MAX_POS);

	always_comb begin
		push_item.ch       = character;
		push_item.has_char = has_char;
		push_item.line_end = line_end;
		push_item.too_long = has_char & at_max;
		push_item.pos      = pos_q;
		push_item.is_blank = (character == CH_SPACE) || (character == CH_TAB);
		push_item.is_lower = (character >= CH_LOW_A) && (character <= CH_LOW_Z);
		push_item.is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
		push_item.is_colon = (character == CH_COLON);
		push_item.is_quote = (character == CH_QUOTE);
	end

	// offset saturates at the line limit; restart at each line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				pos_q <= '0;
			end else if (has_char && !at_max) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/hfp_queue.sv
// Short queue between front and back end of the header field line parser.
// Flip-flop storage of classified beats. Depends on hfp_pkg.
module hfp_queue import hfp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t   mem_q [QDEPTH];
	qptr_t   wr_ptr_q;
	qptr_t   rd_ptr_q;
	qcount_t count_q;
	logic    do_push;
	logic    do_pop;

	assign push_ready = (count_q != qcount_t'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == qptr_t'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == qptr_t'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/hfp_back.sv
// Back end of the header field line parser: walks the line phases, builds the integer
// and keyword match, and registers one result per line end. Depends on hfp_pkg.
module hfp_back import hfp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  res
);

	phase_t  phase_q, n_phase, ph;
	status_t err_q, n_err;
	pos_t    name_begin_q, n_name_begin;
	pos_t    name_count_q, n_name_count;
	pos_t    value_begin_q, n_value_begin;
	pos_t    last_nb_q, n_last_nb;
	num_t    acc_q, n_acc;
	logic    ovf_q, n_ovf;
	logic    digits_q, n_digits;
	wm_t     wm_q, n_wm;
	logic    oq_q, n_oq;
	logic    lq_q, n_lq;
	logic    done;
	logic    gap;
	wm_t     wm_gap;
	logic    dig_gap;
	logic [NUM_W+3:0] prod;
	logic    do_pop;
	logic    out_valid_q;
	res_t    res_q, res_n;
	pos_t    vlen;

	assign out_valid  = out_valid_q;
	assign res        = res_q;
	assign item_ready = !item.line_end || !out_valid_q || out_ready;
	assign do_pop     = item_valid & item_ready;

	// acc * 10 + digit, carry bits flag overflow
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ (NUM_W + 4)'(item.ch - CH_ZERO);

	always_comb begin
		n_phase       = phase_q;
		n_err         = err_q;
		n_name_begin  = name_begin_q;
		n_name_count  = name_count_q;
		n_value_begin = value_begin_q;
		n_last_nb     = last_nb_q;
		n_acc         = acc_q;
		n_ovf         = ovf_q;
		n_digits      = digits_q;
		n_wm          = wm_q;
		n_oq          = oq_q;
		n_lq          = lq_q;
		ph            = phase_q;
		done          = 1'b0;
		gap           = 1'b0;
		wm_gap        = wm_q;
		dig_gap       = digits_q;
		if (item.has_char && err_q != ST_TOO_LONG) begin
			if (item.too_long) begin
				n_err   = ST_TOO_LONG;
				n_phase = PH_ERR;
			end else begin
				if (ph == PH_LEAD) begin
					if (item.is_blank) begin
						done = 1'b1;
					end else begin
						n_name_begin = item.pos;
						ph           = PH_NAME;
					end
				end
				if (!done && ph == PH_NAME) begin
					if (item.is_lower) begin
						n_name_count = name_count_q + 1'b1;
						done         = 1'b1;
					end else begin
						ph = PH_SEP;
					end
				end
				if (!done && ph == PH_SEP) begin
					done = 1'b1;
					if (!item.is_blank) begin
						if (item.is_colon) begin
							ph = PH_GAP;
						end else begin
							n_err = ST_NO_COLON;
							ph    = PH_ERR;
						end
					end
				end
				if (!done && ph == PH_GAP) begin
					if (item.is_blank) begin
						done = 1'b1;
					end else begin
						n_value_begin = item.pos;
						n_oq          = item.is_quote;
						ph            = PH_VALUE;
					end
				end
				if (!done && ph == PH_VALUE && !item.is_blank) begin
					// an interior blank run makes the value a string
					gap     = (item.pos != n_value_begin) && (last_nb_q + 1'b1 != item.pos);
					wm_gap  = gap ? WM_FAIL : wm_q;
					dig_gap = digits_q & ~gap;
					if (item.is_digit) begin
						if (dig_gap && !ovf_q) begin
							if (prod[NUM_W+3:NUM_W] != '0) begin
								n_ovf = 1'b1;
							end else begin
								n_acc = prod[NUM_W-1:0];
							end
						end
						n_digits = dig_gap;
					end else begin
						n_digits = 1'b0;
					end
					n_wm      = wm_next(wm_gap, item.ch);
					n_lq      = item.is_quote;
					n_last_nb = item.pos;
				end
				n_phase = ph;
			end
		end
	end

	always_comb begin
		res_n = '0;
		vlen  = n_last_nb - n_value_begin + 1'b1;
		case (n_phase)
			PH_ERR:           res_n.status = n_err;
			PH_LEAD:          res_n.status = ST_NO_NAME;
			PH_NAME, PH_SEP:  res_n.status = ST_NO_COLON;
			PH_GAP:           res_n.status = ST_NO_VALUE;
			default:          res_n.status = ST_OK;
		endcase
		if (res_n.status == ST_OK) begin
			res_n.name_start   = n_name_begin;
			res_n.name_length  = n_name_count;
			res_n.value_start  = n_value_begin;
			res_n.value_length = vlen;
			if (n_wm == WM_TRUE) begin
				res_n.kind = KIND_BOOL;
				res_n.flag = 1'b1;
			end else if (n_wm == WM_FALSE) begin
				res_n.kind = KIND_BOOL;
			end else if (n_digits) begin
				if (n_ovf) begin
					res_n = '0;
					res_n.status = ST_OVERFLOW;
				end else begin
					res_n.kind   = KIND_UINT;
					res_n.number = n_acc;
				end
			end else begin
				res_n.kind = KIND_STRING;
				// strip enclosing quotes; a lone quote leaves an empty span
				if (n_oq && n_lq) begin
					res_n.value_start  = n_value_begin + 1'b1;
					res_n.value_length = (vlen >= pos_t'(2)) ? vlen - pos_t'(2) : '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && item.line_end) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_pop && item.line_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEAD;
			err_q         <= ST_OK;
			name_begin_q  <= '0;
			name_count_q  <= '0;
			value_begin_q <= '0;
			last_nb_q     <= '0;
			acc_q         <= '0;
			ovf_q         <= 1'b0;
			digits_q      <= 1'b1;
			wm_q          <= WM_START;
			oq_q          <= 1'b0;
			lq_q          <= 1'b0;
		end else if (do_pop) begin
			if (item.line_end) begin
				// line end taken and result registered: start the next line clean
				phase_q       <= PH_LEAD;
				err_q         <= ST_OK;
				name_begin_q  <= '0;
				name_count_q  <= '0;
				value_begin_q <= '0;
				last_nb_q     <= '0;
				acc_q         <= '0;
				ovf_q         <= 1'b0;
				digits_q      <= 1'b1;
				wm_q          <= WM_START;
				oq_q          <= 1'b0;
				lq_q          <= 1'b0;
			end else begin
				phase_q       <= n_phase;
				err_q         <= n_err;
				name_begin_q  <= n_name_begin;
				name_count_q  <= n_name_count;
				value_begin_q <= n_value_begin;
				last_nb_q     <= n_last_nb;
				acc_q         <= n_acc;
				ovf_q         <= n_ovf;
				digits_q      <= n_digits;
				wm_q          <= n_wm;
				oq_q          <= n_oq;
				lq_q          <= n_lq;
			end
		end
	end

endmodule
